// ----- src/thsl_pkg.sv -----
// Package with the shared types, constants and calibration table of the thermistor linearizer.
package thsl_pkg;

	localparam int SUM_W      = 14;
	localparam int TEMP_W     = 12;
	localparam int CNT_W      = 7;
	localparam int TAB_CAP    = 32;
	localparam int IDX_W      = 5;
	localparam int REM_W      = 21;
	localparam int QUO_W      = 7;
	localparam int BIT_W      = 3;

	localparam logic [SUM_W-1:0] SUM_MAX       = 14'd16383;
	localparam logic [CNT_W-1:0] MAX_SAMPLES   = 7'd64;
	localparam logic [CNT_W-1:0] RESET_SAMPLES = 7'd31;
	localparam logic [TEMP_W-1:0] BASE_TEMP_X16 = 12'd1120;
	localparam logic [BIT_W-1:0] TOP_QUO_BIT   = 3'd6;

	localparam logic [SUM_W-1:0] SUM_AT_POINT [TAB_CAP] = '{
		14'd7900, 14'd6850, 14'd5900, 14'd5130, 14'd4460, 14'd3850, 14'd3350, 14'd2930,
		14'd2590, 14'd2232, 14'd1850, 14'd1620, 14'd1430, 14'd1250, 14'd1100, 14'd950,
		14'd850,  14'd0,    14'd0,    14'd0,    14'd0,    14'd0,    14'd0,    14'd0,
		14'd0,    14'd0,    14'd0,    14'd0,    14'd0,    14'd0,    14'd0,    14'd0
	};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RANGE,
		ST_SEARCH,
		ST_SCALE,
		ST_DIVIDE,
		ST_DONE
	} thsl_state_t;

	typedef struct packed {
		logic [TEMP_W-1:0] temperature_x16;
		logic              in_range;
		logic [SUM_W-1:0]  raw_sum;
	} thsl_result_t;

	typedef struct packed {
		logic idle;
		logic res_valid;
	} thsl_ctl_t;

endpackage

// ----- src/thsl_accum.sv -----
// Sample accumulator that sums one window of ADC samples and hands the finished sum on.
module thsl_accum #(
	parameter int SAMPLE_BITS = 8
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      accept,
	input  logic [SAMPLE_BITS-1:0]    sample,
	input  logic [thsl_pkg::CNT_W-1:0] limit,
	output logic                      start,
	output logic [thsl_pkg::SUM_W-1:0] conv_sum
);
	import thsl_pkg::*;

	logic [SUM_W-1:0] sum_q;
	logic [CNT_W-1:0] count_q;
	logic [SUM_W:0]   wide_sum;
	logic [SUM_W-1:0] new_sum;
	logic [CNT_W-1:0] new_count;
	logic             complete;

	always_comb begin
		wide_sum  = {1'b0, sum_q} + (SUM_W+1)'(sample);
		new_sum   = (wide_sum > {1'b0, SUM_MAX}) ? SUM_MAX : wide_sum[SUM_W-1:0];
		new_count = count_q + 7'd1;
		complete  = (new_count >= limit);
		start     = accept && complete;
		conv_sum  = new_sum;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			count_q <= '0;
		end else if (accept) begin
			if (complete) begin
				sum_q   <= '0;
				count_q <= '0;
			end else begin
				sum_q   <= new_sum;
				count_q <= new_count;
			end
		end
	end

endmodule

// ----- src/thsl_subu.sv -----
// Shared subtract and compare unit used for the segment search and the restoring division.
module thsl_subu (
	input  logic [thsl_pkg::REM_W-1:0] a,
	input  logic [thsl_pkg::REM_W-1:0] b,
	output logic [thsl_pkg::REM_W-1:0] diff,
	output logic                       borrow
);
	import thsl_pkg::*;

	logic [REM_W:0] full;

	always_comb begin
		full   = {1'b0, a} - {1'b0, b};
		diff   = full[REM_W-1:0];
		borrow = full[REM_W];
	end

endmodule

// ----- src/thsl_interp.sv -----
// Sequencer that searches the table segment and interpolates the temperature by serial division.
module thsl_interp #(
	parameter int TABLE_POINTS = 17
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [thsl_pkg::SUM_W-1:0]   start_sum,
	input  logic                         res_take,
	output thsl_pkg::thsl_ctl_t          ctl,
	output thsl_pkg::thsl_result_t       res
);
	import thsl_pkg::*;

	localparam int NPTS = (TABLE_POINTS < 2) ? 2 :
		((TABLE_POINTS > TAB_CAP) ? TAB_CAP : TABLE_POINTS);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NPTS - 1);
	localparam logic [IDX_W-1:0] LAST_SEG = IDX_W'(NPTS - 2);

	thsl_state_t       state_q, state_d;
	logic [SUM_W-1:0]  sum_q;
	logic [IDX_W-1:0]  idx_q;
	logic [REM_W-1:0]  rem_q;
	logic [SUM_W-1:0]  div_q;
	logic [QUO_W-1:0]  quo_q;
	logic [BIT_W-1:0]  k_q;
	logic [TEMP_W-1:0] temp_q;
	logic              valid_q;

	logic [SUM_W-1:0]  hi, lo;
	logic              in_span, found, slope_ok;
	logic [REM_W-1:0]  sub_a, sub_b, sub_diff;
	logic              sub_borrow;
	logic [QUO_W-1:0]  quo_new;
	logic [TEMP_W-1:0] seg_base;

	thsl_subu u_subu (
		.a      (sub_a),
		.b      (sub_b),
		.diff   (sub_diff),
		.borrow (sub_borrow)
	);

	always_comb begin
		hi       = SUM_AT_POINT[idx_q];
		lo       = SUM_AT_POINT[idx_q + 5'd1];
		in_span  = (sum_q < SUM_AT_POINT[0]) && (sum_q > SUM_AT_POINT[LAST_IDX]);
		if (state_q == ST_DIVIDE) begin
			sub_a = rem_q;
			sub_b = REM_W'(div_q) << k_q;
		end else begin
			sub_a = REM_W'(sum_q);
			sub_b = REM_W'(lo);
		end
		found    = !sub_borrow;
		slope_ok = (hi > lo) && (hi >= sum_q);
		quo_new  = quo_q | (sub_borrow ? 7'd0 : (7'd1 << k_q));
		seg_base = BASE_TEMP_X16 + (TEMP_W'(idx_q) << 6) + (TEMP_W'(idx_q) << 4);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:   if (start) state_d = ST_RANGE;
			ST_RANGE:  state_d = in_span ? ST_SEARCH : ST_DONE;
			ST_SEARCH: begin
				if (found) begin
					state_d = slope_ok ? ST_SCALE : ST_DONE;
				end else if (idx_q == LAST_SEG) begin
					state_d = ST_DONE;
				end
			end
			ST_SCALE:  state_d = ST_DIVIDE;
			ST_DIVIDE: if (k_q == '0) state_d = ST_DONE;
			ST_DONE:   if (res_take) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ctl.idle      = 1'b0;
		ctl.res_valid = 1'b0;
		case (state_q)
			ST_IDLE: ctl.idle      = 1'b1;
			ST_DONE: ctl.res_valid = 1'b1;
			default: begin
				ctl.idle      = 1'b0;
				ctl.res_valid = 1'b0;
			end
		endcase
		res.temperature_x16 = temp_q;
		res.in_range        = valid_q;
		res.raw_sum         = sum_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					sum_q   <= start_sum;
					idx_q   <= '0;
					valid_q <= 1'b0;
					temp_q  <= '0;
				end
			end
			ST_SEARCH: begin
				if (found) begin
					valid_q <= 1'b1;
					temp_q  <= seg_base;
					rem_q   <= REM_W'(hi - sum_q);
					div_q   <= hi - lo;
					k_q     <= TOP_QUO_BIT;
					quo_q   <= '0;
				end else begin
					idx_q <= idx_q + 5'd1;
				end
			end
			ST_SCALE: rem_q <= (rem_q << 6) + (rem_q << 4);
			ST_DIVIDE: begin
				if (!sub_borrow) rem_q <= sub_diff;
				quo_q <= quo_new;
				k_q   <= k_q - 3'd1;
				if (k_q == '0) temp_q <= temp_q + TEMP_W'(quo_new);
			end
			default: begin
			end
		endcase
	end

endmodule

// ----- src/thermistor_sum_linearizer_top.sv -----
// Top level of the thermistor sum linearizer with configuration and output registers.
// A sample that does not close a window is taken and leaves the block ready for the next sample.
// A window-closing sample holds the block for a range check, then, for a sum in the table
// span, one table compare a cycle and, if a segment is found, a scaling step and seven
// division steps, then a hand-over to the output register. Compares and division steps share
// one subtractor. The hand-over waits while the output register holds an untaken request.
// The result waits in the output register while further samples are taken.
// Reset is asynchronous and active low; it clears the sum, count and handshakes and
// sets the window length to 31 samples.
module thermistor_sum_linearizer_top #(
	parameter int TABLE_POINTS = 17,
	parameter int SAMPLE_BITS  = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [thsl_pkg::CNT_W-1:0]    cfg_wdata,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [SAMPLE_BITS-1:0]        adc_sample,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [thsl_pkg::TEMP_W-1:0]   temperature_x16,
	output logic                          in_range,
	output logic [thsl_pkg::SUM_W-1:0]    raw_sum
);
	import thsl_pkg::*;

	logic [CNT_W-1:0] spa_q;
	logic [CNT_W-1:0] limit;
	logic             accept;
	logic             start;
	logic [SUM_W-1:0] conv_sum;
	logic             res_take;
	thsl_ctl_t        ctl;
	thsl_result_t     res;
	logic             out_valid_q;
	thsl_result_t     out_q;

	always_comb begin
		if (spa_q == '0) begin
			limit = 7'd1;
		end else if (spa_q > MAX_SAMPLES) begin
			limit = MAX_SAMPLES;
		end else begin
			limit = spa_q;
		end
		in_ready = ctl.idle;
		accept   = in_valid && in_ready;
		res_take = ctl.res_valid && (!out_valid_q || out_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spa_q <= RESET_SAMPLES;
		end else if (cfg_we) begin
			spa_q <= cfg_wdata;
		end
	end

	thsl_accum #(.SAMPLE_BITS(SAMPLE_BITS)) u_accum (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.sample   (adc_sample),
		.limit    (limit),
		.start    (start),
		.conv_sum (conv_sum)
	);

	thsl_interp #(.TABLE_POINTS(TABLE_POINTS)) u_interp (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.start_sum (conv_sum),
		.res_take  (res_take),
		.ctl       (ctl),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) out_q <= res;
	end

	assign out_valid       = out_valid_q;
	assign temperature_x16 = out_q.temperature_x16;
	assign in_range        = out_q.in_range;
	assign raw_sum         = out_q.raw_sum;

endmodule

// ----- src/thsl_checker.sv -----
// Port-level checker for the thermistor linearizer, bound to the top level.
module thsl_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [thsl_pkg::TEMP_W-1:0] temperature_x16,
	input logic                        in_range,
	input logic [thsl_pkg::SUM_W-1:0]  raw_sum
);
	import thsl_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(temperature_x16) &&
		$stable(in_range) && $stable(raw_sum))
		else $error("A pending result request changed before it was taken.");

	a_zero_out_of_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !in_range |-> temperature_x16 == '0)
		else $error("An out-of-range result carries a non-zero temperature.");

	a_temp_floor: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && in_range |-> temperature_x16 >= BASE_TEMP_X16)
		else $error("An in-range temperature lies below the first table point.");

	a_sum_span: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && in_range |-> raw_sum < SUM_AT_POINT[0] && raw_sum != '0)
		else $error("An in-range result carries a sum outside the table span.");

endmodule

bind thermistor_sum_linearizer_top thsl_checker u_thsl_checker (.*);
